// ===== hdl/sorted_region_table_assert.svh =====
// assertion macros shared by the region table rtl
`ifndef SORTED_REGION_TABLE_ASSERT_SVH
`define SORTED_REGION_TABLE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted region table check failed");

// next-cycle implication checked outside reset
`define SRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted region table check failed");

`endif

// ===== hdl/srt_pkg.sv =====
package srt_pkg;

  localparam int unsigned DefEntries    = 32;
  localparam int unsigned DefHandleBits = 16;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned OpW           = 3;
  localparam int unsigned StW           = 2;
  localparam int unsigned HandleW       = 16;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_DELETE = 3'd2,
    OP_RANGE  = 3'd3,
    OP_BIGGER = 3'd4
  } op_e;

  localparam logic [StW-1:0] ST_OK   = 2'd0;
  localparam logic [StW-1:0] ST_MISS = 2'd1;
  localparam logic [StW-1:0] ST_FULL = 2'd2;

endpackage

// ===== hdl/sorted_region_table.sv =====
// channel   | direction | ports                                   | handshake
// request   | in        | op_i key_i region_size_i handle_i       | start_i while !busy_o
// result    | out       | status_o hit_handle_o hit_key_o         | done_o, one cycle
//           |           | hit_size_o table_empty_o                |
//
// every scanned entry takes a read issue state and a compare state, and busy_o stays
// high through lookup, range and next-bigger scans; insert and delete add one read
// and one write per shifted entry, and a full insert or unused opcode goes straight
// to S_DONE. the memory takes at most one access per cycle.
// reset (rst_ni low, asynchronous) empties the table; entries are not cleared.
// the result cannot be stalled: done_o pulses one cycle and busy_o drops after it.
module sorted_region_table
  import srt_pkg::*;
#(
  parameter int unsigned Entries    = DefEntries,
  parameter int unsigned HandleBits = DefHandleBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [KeyW-1:0]    region_size_i,
  input  logic [HandleW-1:0] handle_i,
  output logic               done_o,
  output logic [StW-1:0]     status_o,
  output logic [HandleW-1:0] hit_handle_o,
  output logic [KeyW-1:0]    hit_key_o,
  output logic [KeyW-1:0]    hit_size_o,
  output logic               table_empty_o
);
`include "sorted_region_table_assert.svh"

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Entries);

  // one entry: key, size, handle packed in one memory word
  typedef struct packed {
    logic [KeyW-1:0]       key;
    logic [KeyW-1:0]       size;
    logic [HandleBits-1:0] hnd;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010, // issue read of entry idx
    S_CHK   = 7'b0000100, // compare read data
    S_SHIFT = 7'b0001000, // read back entry for insert shift
    S_SWR   = 7'b0010000, // write shifted entry
    S_DEL   = 7'b0100000, // delete shift step
    S_DONE  = 7'b1000000
  } state_e;

  entry_t mem [Entries];
  entry_t rdata_q;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [OpW-1:0]  op_q;
  logic [KeyW-1:0] key_q, size_q;
  logic [HandleBits-1:0] hnd_q;
  // best candidate for range lookup (first of the greatest key at or below)
  logic            cand_q, cand_d;
  entry_t          best_q, best_d;
  logic [CntW-1:0] pos_q, pos_d;

  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  entry_t          wdata;

  logic            done_d;
  logic [StW-1:0]  st_d;
  entry_t          hit_d;
  logic            hitv_d;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    cand_d  = cand_q;
    best_d  = best_q;
    pos_d   = pos_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = idx_q[IdxW-1:0];
    wr_addr = idx_q[IdxW-1:0];
    wdata   = rdata_q;
    done_d  = 1'b0;
    st_d    = ST_MISS;
    hit_d   = '0;
    hitv_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d  = '0;
          cand_d = 1'b0;
          if (op_i == OP_INSERT && cnt_q == CntFull) begin
            done_d  = 1'b1;
            st_d    = ST_FULL;
            state_d = S_DONE;
          end else if (op_i > OP_BIGGER) begin
            done_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q == cnt_q) begin
          // end of live entries
          done_d  = 1'b1;
          state_d = S_DONE;
          case (op_q)
            OP_INSERT: begin
              pos_d = cnt_q;
              done_d = 1'b0;
              state_d = S_SHIFT;
              idx_d = cnt_q;
            end
            OP_RANGE: begin
              if (cand_q && (key_q - best_q.key < best_q.size)) begin
                st_d = ST_OK; hit_d = best_q; hitv_d = 1'b1;
              end
            end
            default: ;
          endcase
        end else begin
          rd_en   = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = S_SCAN;
        idx_d   = idx_q + 1'b1;
        case (op_q)
          OP_INSERT: begin
            if (rdata_q.key > key_q) begin
              pos_d   = idx_q;
              idx_d   = cnt_q;
              state_d = S_SHIFT;
            end
          end
          OP_LOOKUP: begin
            if (rdata_q.key == key_q) begin
              st_d = ST_OK; hit_d = rdata_q; hitv_d = 1'b1;
              done_d = 1'b1; state_d = S_DONE;
            end else if (rdata_q.key > key_q) begin
              done_d = 1'b1; state_d = S_DONE;
            end
          end
          OP_DELETE: begin
            if (rdata_q.key == key_q) begin
              st_d = ST_OK; hit_d = rdata_q; hitv_d = 1'b1;
              // stay on the removed slot for the shift
              idx_d = idx_q;
              state_d = S_DEL;
            end else if (rdata_q.key > key_q) begin
              done_d = 1'b1; state_d = S_DONE;
            end
          end
          OP_RANGE: begin
            if (rdata_q.key <= key_q) begin
              if (!cand_q || rdata_q.key != best_q.key) begin
                best_d = rdata_q;
              end
              cand_d = 1'b1;
            end else begin
              done_d = 1'b1; state_d = S_DONE;
              if (cand_q && (key_q - best_q.key < best_q.size)) begin
                st_d = ST_OK; hit_d = best_q; hitv_d = 1'b1;
              end
            end
          end
          default: begin
            if (rdata_q.key > key_q) begin
              st_d = ST_OK; hit_d = rdata_q; hitv_d = 1'b1;
              done_d = 1'b1; state_d = S_DONE;
            end
          end
        endcase
      end
      S_SHIFT: begin
        // idx moves down from count to pos
        if (idx_q == pos_q) begin
          wr_en   = 1'b1;
          wdata   = '{key: key_q, size: size_q, hnd: hnd_q};
          cnt_d   = cnt_q + 1'b1;
          st_d    = ST_OK;
          done_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(idx_q - 1'b1);
          state_d = S_SWR;
        end
      end
      S_SWR: begin
        wr_en   = 1'b1;
        idx_d   = idx_q - 1'b1;
        state_d = S_SHIFT;
      end
      S_DEL: begin
        // idx points at the removed slot; pull entry idx+1 down
        if (idx_q + 1'b1 >= cnt_q) begin
          cnt_d   = cnt_q - 1'b1;
          st_d    = ST_OK;
          hit_d   = best_q;
          hitv_d  = 1'b1;
          done_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(idx_q + 1'b1);
          state_d = S_SWR;
          idx_d   = idx_q;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // delete write-back reuses S_SWR with upward motion
    if (state_q == S_SWR && op_q == OP_DELETE) begin
      idx_d   = idx_q + 1'b1;
      state_d = S_DEL;
    end
    if (state_q == S_CHK && op_q == OP_DELETE && hitv_d) begin
      best_d = rdata_q;
      done_d = 1'b0;
      hitv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cand_q <= cand_d;
    best_q <= best_d;
    pos_q  <= pos_d;
    if (state_q == S_IDLE && start_i) begin
      op_q   <= op_i;
      key_q  <= key_i;
      size_q <= region_size_i;
      hnd_q  <= handle_i[HandleBits-1:0];
    end
    if (done_d) begin
      status_o      <= st_d;
      hit_key_o     <= hitv_d ? hit_d.key  : '0;
      hit_size_o    <= hitv_d ? hit_d.size : '0;
      hit_handle_o  <= hitv_d ? HandleW'(hit_d.hnd) : '0;
      table_empty_o <= (cnt_d == '0);
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `SRT_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntFull)
  `SRT_ASSERT_NXT(a_done_after_busy, clk_i, rst_ni, done_o, !busy_o)
  `SRT_ASSERT_IMP(a_no_wr_idle, clk_i, rst_ni, state_q == S_IDLE, !wr_en)
  `SRT_ASSERT_NXT(a_full_stays, clk_i, rst_ni,
    state_q == S_IDLE && start_i && op_i == OP_INSERT && cnt_q == CntFull,
    cnt_q == CntFull)

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import srt_pkg::*;

  localparam int unsigned TableDepth = DefEntries;
  localparam int unsigned ItemsPerPhase = 275;
  localparam int unsigned DrainCycles = 2 * TableDepth + 16;
  // opcodes the block must ignore
  localparam logic [OpW-1:0] OpSpareLo  = 3'd5;
  localparam logic [OpW-1:0] OpSpareMid = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi  = 3'd7;
  localparam logic [KeyW-1:0] KeyMax = '1;

  typedef struct packed {
    logic [StW-1:0]     status;
    logic [HandleW-1:0] handle;
    logic [KeyW-1:0]    start_key;
    logic [KeyW-1:0]    size;
    logic               empty;
  } region_result_t;

  typedef struct {
    logic [OpW-1:0]     op;
    logic [KeyW-1:0]    key;
    logic [KeyW-1:0]    size;
    logic [HandleW-1:0] handle;
    bit                 typed;
    region_result_t     res;
  } directed_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [OpW-1:0]     op_i = '0;
  logic [KeyW-1:0]    key_i = '0;
  logic [KeyW-1:0]    region_size_i = '0;
  logic [HandleW-1:0] handle_i = '0;
  logic               done_o;
  logic [StW-1:0]     status_o;
  logic [HandleW-1:0] hit_handle_o;
  logic [KeyW-1:0]    hit_key_o;
  logic [KeyW-1:0]    hit_size_o;
  logic               table_empty_o;

  sorted_region_table dut (.*);

  always #2 clk_i = ~clk_i;

  // shadow copy of the region table
  logic [KeyW-1:0]    shadow_keys[TableDepth];
  logic [KeyW-1:0]    shadow_sizes[TableDepth];
  logic [HandleW-1:0] shadow_handles[TableDepth];
  int unsigned        shadow_count = 0;

  region_result_t pending_results[$];
  int unsigned    accepted_requests = 0;
  bit             failed = 1'b0;
  // a typed expectation that replaces the predicted one for the next request
  bit             typed_valid = 1'b0;
  region_result_t typed_res;

  // index of the first live entry at or above k, or strictly above when strict
  function automatic int unsigned first_slot(logic [KeyW-1:0] k, bit strict);
    int unsigned i;
    i = 0;
    while (i < shadow_count && (strict ? shadow_keys[i] <= k : shadow_keys[i] < k)) i++;
    return i;
  endfunction

  function automatic region_result_t apply_region_op(logic [OpW-1:0] op,
      logic [KeyW-1:0] key, logic [KeyW-1:0] size, logic [HandleW-1:0] hnd);
    region_result_t r;
    bit hit;
    int unsigned idx;
    int unsigned above;
    logic [KeyW-1:0] best;
    r = '0;
    r.status = ST_MISS;
    hit = 1'b0;
    idx = 0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          // newer duplicates go behind the older ones
          idx = first_slot(key, 1'b1);
          for (int j = shadow_count; j > idx; j--) begin
            shadow_keys[j] = shadow_keys[j-1];
            shadow_sizes[j] = shadow_sizes[j-1];
            shadow_handles[j] = shadow_handles[j-1];
          end
          shadow_keys[idx] = key;
          shadow_sizes[idx] = size;
          shadow_handles[idx] = hnd;
          shadow_count++;
          r.status = ST_OK;
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        idx = first_slot(key, 1'b0);
        hit = idx < shadow_count && shadow_keys[idx] == key;
      end
      OP_RANGE: begin
        above = first_slot(key, 1'b1);
        if (above > 0) begin
          best = shadow_keys[above-1];
          // oldest entry among those sharing the best start
          idx = first_slot(best, 1'b0);
          hit = (key - best) < shadow_sizes[idx];
        end
      end
      OP_BIGGER: begin
        idx = first_slot(key, 1'b1);
        hit = idx < shadow_count;
      end
      default: ;
    endcase
    if (hit) begin
      r.status = ST_OK;
      r.start_key = shadow_keys[idx];
      r.size = shadow_sizes[idx];
      r.handle = shadow_handles[idx];
      if (op == OP_DELETE) begin
        for (int j = idx; j + 1 < shadow_count; j++) begin
          shadow_keys[j] = shadow_keys[j+1];
          shadow_sizes[j] = shadow_sizes[j+1];
          shadow_handles[j] = shadow_handles[j+1];
        end
        shadow_count--;
      end
    end
    r.empty = shadow_count == 0;
    return r;
  endfunction

  // result check first, then book the request taken at this edge
  always @(posedge clk_i) begin
    region_result_t got;
    region_result_t want;
    region_result_t predicted;
    if (rst_ni && done_o) begin
      got = '{status_o, hit_handle_o, hit_key_o, hit_size_o, table_empty_o};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.handle !== want.handle)
          $display("%0t: hit_handle expected %h actual %h", $time, want.handle, got.handle);
        if (got.start_key !== want.start_key)
          $display("%0t: hit_key expected %h actual %h", $time, want.start_key,
                   got.start_key);
        if (got.size !== want.size)
          $display("%0t: hit_size expected %h actual %h", $time, want.size, got.size);
        if (got.empty !== want.empty)
          $display("%0t: table_empty expected %0d actual %0d", $time, want.empty, got.empty);
        if (got !== want) failed = 1'b1;
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      predicted = apply_region_op(op_i, key_i, region_size_i, handle_i);
      pending_results.push_back(typed_valid ? typed_res : predicted);
      accepted_requests++;
    end
  end

  // drive one request at the falling edge and hold it until taken
  task automatic issue_request(logic [OpW-1:0] op, logic [KeyW-1:0] key,
      logic [KeyW-1:0] size, logic [HandleW-1:0] hnd, bit typed, region_result_t res);
    int unsigned seen;
    seen = accepted_requests;
    start_i <= 1'b1;
    op_i <= op;
    key_i <= key;
    region_size_i <= size;
    handle_i <= hnd;
    typed_valid <= typed;
    typed_res <= res;
    do @(negedge clk_i); while (accepted_requests == seen);
  endtask

  function automatic logic [KeyW-1:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  // keys near live entries so that lookups and range queries hit often
  function automatic logic [KeyW-1:0] pick_key();
    logic [KeyW-1:0] base;
    case ($urandom_range(0, 9))
      0: return rand_wide();
      1: return $urandom_range(0, 1) ? '0 : KeyMax;
      default: begin
        base = shadow_count ? shadow_keys[$urandom_range(0, shadow_count - 1)]
                            : {4'($urandom_range(0, 3)), 60'h0} |
                              KeyW'($urandom_range(0, 4095));
        return base + KeyW'($urandom_range(0, 6)) - KeyW'(3);
      end
    endcase
  endfunction

  directed_row_t directed_rows[$];

  initial begin
    region_result_t miss_empty;
    region_result_t ok_empty;
    region_result_t ok_live;
    region_result_t none;
    region_result_t full_res;
    logic [OpW-1:0] op;
    logic [KeyW-1:0] size;
    int unsigned gap_pct;
    int unsigned roll;
    int unsigned insert_pct;
    int unsigned delete_pct;

    miss_empty = '{ST_MISS, '0, '0, '0, 1'b1};
    ok_empty   = '{ST_OK, '0, '0, '0, 1'b1};
    ok_live    = '{ST_OK, '0, '0, '0, 1'b0};
    full_res   = '{ST_FULL, '0, '0, '0, 1'b0};
    none       = '0;

    // empty table, every operation misses
    directed_rows.push_back('{OP_LOOKUP, '0, '0, '0, 1, miss_empty});
    directed_rows.push_back('{OP_DELETE, 64'd5, '0, '0, 1, miss_empty});
    directed_rows.push_back('{OP_RANGE, KeyMax, '0, '0, 1, miss_empty});
    directed_rows.push_back('{OP_BIGGER, '0, '0, '0, 1, miss_empty});
    directed_rows.push_back('{OpSpareHi, KeyMax, KeyMax, '1, 1, miss_empty});
    // extremes of every field, plus a duplicate start
    directed_rows.push_back('{OP_INSERT, '0, KeyMax, '1, 1, ok_live});
    directed_rows.push_back('{OP_INSERT, KeyMax, 64'd1, '0, 1, ok_live});
    directed_rows.push_back('{OP_INSERT, '0, 64'd5, 16'd1, 1, ok_live});
    directed_rows.push_back('{OP_LOOKUP, '0, '0, '0, 0, none});
    directed_rows.push_back('{OP_RANGE, KeyMax, '0, '0, 0, none});
    directed_rows.push_back('{OP_RANGE, KeyMax - 1, '0, '0, 0, none});
    // zero-size region never matches a range query
    directed_rows.push_back('{OP_INSERT, 64'd100, '0, 16'h5a5a, 1, ok_live});
    directed_rows.push_back('{OP_RANGE, 64'd100, '0, '0, 0, none});
    directed_rows.push_back('{OP_BIGGER, '0, '0, '0, 0, none});
    directed_rows.push_back('{OP_BIGGER, KeyMax, '0, '0, 0, none});
    directed_rows.push_back('{OpSpareLo, 64'd100, '0, '0, 0, none});
    directed_rows.push_back('{OpSpareMid, '0, '0, '0, 0, none});
    // delete walks the duplicates oldest first
    directed_rows.push_back('{OP_DELETE, '0, '0, '0, 0, none});
    directed_rows.push_back('{OP_DELETE, '0, '0, '0, 0, none});
    directed_rows.push_back('{OP_DELETE, '0, '0, '0, 0, none});
    directed_rows.push_back('{OP_DELETE, 64'd100, '0, '0, 0, none});
    directed_rows.push_back('{OP_DELETE, KeyMax, '0, '0, 0, none});
    directed_rows.push_back('{OP_INSERT, 64'h8000_0000_0000_0000, 64'd1, 16'h8000, 0, none});
    directed_rows.push_back('{OP_DELETE, 64'h8000_0000_0000_0000, '0, '0, 1,
                              '{ST_OK, 16'h8000, 64'h8000_0000_0000_0000, 64'd1, 1'b1}});

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].size,
                    directed_rows[i].handle, directed_rows[i].typed, directed_rows[i].res);

    // fill to capacity, then one insert too many
    while (shadow_count < TableDepth)
      issue_request(OP_INSERT, pick_key(), rand_wide(), $urandom, 0, none);
    issue_request(OP_INSERT, rand_wide(), rand_wide(), $urandom, 1, full_res);
    start_i <= 1'b0;

    // random traffic: sender gaps vary per phase, mix drifts between fill and drain
    for (int phase = 0; phase < 4; phase++) begin
      gap_pct = (phase == 1) ? 49 : (phase == 3) ? 32 : 0;
      insert_pct = (phase % 2 == 0) ? 45 : 25;
      delete_pct = (phase % 2 == 0) ? 15 : 35;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) op = OP_INSERT;
        else if (roll < insert_pct + delete_pct) op = OP_DELETE;
        else if (roll < 95) op = OpW'($urandom_range(OP_LOOKUP, OP_BIGGER));
        else op = OpW'($urandom_range(OpSpareLo, OpSpareHi));
        case ($urandom_range(0, 7))
          0: size = rand_wide();
          1: size = '0;
          2: size = KeyMax;
          default: size = KeyW'($urandom_range(1, 64));
        endcase
        issue_request(op, pick_key(), size, $urandom, 0, none);
        if ($urandom_range(0, 99) < gap_pct) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 2 * TableDepth + 4)) @(negedge clk_i);
        end
      end
      start_i <= 1'b0;
      @(negedge clk_i);
    end

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (!failed && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
